// ----- rtl/assert_macros.svh -----
// Assertion macros used by the sequencer RTL of the packed decimal converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`else
`define ASSERT_CLKD(lbl, ck, rn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

// ----- rtl/pdc_pkg.sv -----
// Types, constants and the power-of-ten table of the packed decimal converter.
`default_nettype none

package pdc_pkg;

  localparam int WordW  = 52;
  localparam int PackW  = 64;
  localparam int ValueW = 51;

  typedef logic [WordW-1:0] word_t;

  // Configuration register indexes
  localparam logic REG_PLUS  = 1'b0;
  localparam logic REG_MINUS = 1'b1;

  // Item kinds
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef struct packed {
    logic [3:0] plus_code;
    logic [3:0] minus_code;
  } sign_cfg_t;

  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } alu_req_t;

  typedef struct packed {
    word_t sum;
    logic  cout;
  } alu_rsp_t;

  typedef struct packed {
    logic [PackW-1:0] packed_out;
    logic [WordW-1:0] value_out;
    logic             out_of_range;
  } res_t;

  function automatic word_t pow10(input logic [3:0] idx);
    word_t p;
    case (idx)
      4'd0:    p = 52'd1;
      4'd1:    p = 52'd10;
      4'd2:    p = 52'd100;
      4'd3:    p = 52'd1000;
      4'd4:    p = 52'd10000;
      4'd5:    p = 52'd100000;
      4'd6:    p = 52'd1000000;
      4'd7:    p = 52'd10000000;
      4'd8:    p = 52'd100000000;
      4'd9:    p = 52'd1000000000;
      4'd10:   p = 52'd10000000000;
      4'd11:   p = 52'd100000000000;
      4'd12:   p = 52'd1000000000000;
      4'd13:   p = 52'd10000000000000;
      4'd14:   p = 52'd100000000000000;
      default: p = 52'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pdc_addsub.sv -----
// Shared 52-bit adder/subtractor with carry out (carry set means no borrow).
`default_nettype none

module pdc_addsub (
  input  pdc_pkg::alu_req_t req,
  output pdc_pkg::alu_rsp_t rsp
);

  logic [pdc_pkg::WordW-1:0] b_eff;
  logic [pdc_pkg::WordW:0]   sum_ext;

  assign b_eff   = req.sub ? ~req.b : req.b;
  assign sum_ext = {1'b0, req.a} + {1'b0, b_eff} + (pdc_pkg::WordW+1)'(req.sub);

  assign rsp.sum  = sum_ext[pdc_pkg::WordW-1:0];
  assign rsp.cout = sum_ext[pdc_pkg::WordW];

endmodule

`default_nettype wire

// ----- rtl/pdc_regs.sv -----
// APB-style configuration registers holding the plus and minus sign codes.
`default_nettype none

module pdc_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output pdc_pkg::sign_cfg_t  sign
);

  logic [3:0] plus_r, plus_nxt;
  logic [3:0] minus_r, minus_nxt;
  logic       wr_en;
  logic       idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[2];

  always_comb begin
    plus_nxt  = plus_r;
    minus_nxt = minus_r;
    if (wr_en) begin
      unique case (idx)
        pdc_pkg::REG_PLUS:  plus_nxt  = cfg_pwdata[3:0];
        pdc_pkg::REG_MINUS: minus_nxt = cfg_pwdata[3:0];
        default:            plus_nxt  = plus_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pdc_pkg::REG_PLUS:  cfg_prdata = {28'd0, plus_r};
      pdc_pkg::REG_MINUS: cfg_prdata = {28'd0, minus_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r  <= 4'd12;
      minus_r <= 4'd13;
    end else begin
      plus_r  <= plus_nxt;
      minus_r <= minus_nxt;
    end
  end

  assign sign.plus_code  = plus_r;
  assign sign.minus_code = minus_r;

endmodule

`default_nettype wire

// ----- rtl/pdc_seq.sv -----
// Sequencer and datapath: digit extraction and Horner decode on the shared adder.
`default_nettype none
`include "assert_macros.svh"

module pdc_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic signed [50:0]        in_value,
  input  logic [3:0]                in_packed_bytes,
  input  logic [63:0]               in_packed_in,
  input  pdc_pkg::sign_cfg_t        sign,
  output logic                      res_valid,
  input  logic                      res_take,
  output pdc_pkg::res_t             res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEG  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIG  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_SGN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic                 kind_r, kind_nxt;
  logic                 neg_r, neg_nxt;
  logic [3:0]           nbytes_r, nbytes_nxt;
  pdc_pkg::word_t       mag_r, mag_nxt;
  logic [63:0]          pin_r, pin_nxt;
  logic [3:0]           pos_r, pos_nxt;
  logic [1:0]           bit_r, bit_nxt;
  logic [3:0]           dig_r, dig_nxt;
  logic [63:0]          res_r, res_nxt;
  logic                 oor_r, oor_nxt;

  pdc_pkg::alu_req_t    alu_req;
  pdc_pkg::alu_rsp_t    alu_rsp;

  logic [3:0]           digits;
  logic                 nbytes_bad;
  logic [3:0]           pos_m1;
  logic [3:0]           dig_try;
  logic [3:0]           sign_nib;

  pdc_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign digits     = 4'({nbytes_r, 1'b0} - 5'd1);
  assign nbytes_bad = (nbytes_r == 4'd0) || (nbytes_r > 4'd8);
  assign pos_m1     = pos_r - 4'd1;
  assign dig_try    = dig_r | (4'(alu_rsp.cout) << bit_r);
  assign sign_nib   = neg_r ? sign.minus_code : sign.plus_code;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  // Operand select for the shared adder
  always_comb begin
    alu_req.a   = mag_r;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state_r) inside
      ST_NEG, ST_SGN: begin
        alu_req.a   = '0;
        alu_req.b   = mag_r;
        alu_req.sub = 1'b1;
      end
      ST_CHK: begin
        alu_req.b   = pdc_pkg::pow10(digits);
        alu_req.sub = 1'b1;
      end
      ST_DIG: begin
        alu_req.b   = pdc_pkg::word_t'(pdc_pkg::pow10(pos_m1) << bit_r);
        alu_req.sub = 1'b1;
      end
      ST_MUL: begin
        alu_req.a = pdc_pkg::word_t'(mag_r << 3);
        alu_req.b = pdc_pkg::word_t'(mag_r << 1);
      end
      ST_ADD: begin
        alu_req.b = pdc_pkg::word_t'(pin_r[63:60]);
      end
      default: begin
        alu_req.a = mag_r;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    neg_nxt    = neg_r;
    nbytes_nxt = nbytes_r;
    mag_nxt    = mag_r;
    pin_nxt    = pin_r;
    pos_nxt    = pos_r;
    bit_nxt    = bit_r;
    dig_nxt    = dig_r;
    res_nxt    = res_r;
    oor_nxt    = oor_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          neg_nxt    = in_value[50];
          nbytes_nxt = in_packed_bytes;
          pin_nxt    = in_packed_in;
          oor_nxt    = 1'b0;
          res_nxt    = '0;
          if (in_kind == pdc_pkg::KIND_DEC) begin
            mag_nxt   = '0;
            pos_nxt   = 4'd15;
            state_nxt = ST_MUL;
          end else begin
            mag_nxt   = {1'b0, $unsigned(in_value)};
            state_nxt = ST_NEG;
          end
        end
      end
      ST_NEG: begin
        if (neg_r) begin
          mag_nxt = {1'b0, alu_rsp.sum[pdc_pkg::ValueW-1:0]};
        end
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // carry set: magnitude reaches the digit capacity
        if (nbytes_bad || alu_rsp.cout) begin
          oor_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          pos_nxt   = digits;
          bit_nxt   = 2'd3;
          dig_nxt   = 4'd0;
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (alu_rsp.cout) begin
          mag_nxt = alu_rsp.sum;
        end
        bit_nxt = bit_r - 2'd1;
        dig_nxt = dig_try;
        if (bit_r == 2'd0) begin
          res_nxt = res_r | (64'(dig_try) << {pos_r, 2'b00});
          dig_nxt = 4'd0;
          pos_nxt = pos_m1;
          if (pos_r == 4'd1) begin
            res_nxt   = res_r | (64'(dig_try) << {pos_r, 2'b00}) | 64'(sign_nib);
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        mag_nxt   = alu_rsp.sum;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        mag_nxt = alu_rsp.sum;
        pin_nxt = pin_r << 4;
        pos_nxt = pos_m1;
        if (pos_r == 4'd1) begin
          state_nxt = ST_SGN;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_SGN: begin
        // sign nibble has shifted up to the top
        if (pin_r[63:60] == sign.minus_code) begin
          mag_nxt = alu_rsp.sum;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    neg_r    <= neg_nxt;
    nbytes_r <= nbytes_nxt;
    mag_r    <= mag_nxt;
    pin_r    <= pin_nxt;
    pos_r    <= pos_nxt;
    bit_r    <= bit_nxt;
    dig_r    <= dig_nxt;
    res_r    <= res_nxt;
    oor_r    <= oor_nxt;
  end

  assign res.packed_out   = (kind_r == pdc_pkg::KIND_DEC) ? 64'd0 : res_r;
  assign res.value_out    = (kind_r == pdc_pkg::KIND_DEC) ? mag_r : '0;
  assign res.out_of_range = (kind_r == pdc_pkg::KIND_ENC) && oor_r;

  `ASSERT_DEF(a_oor_zero, (state_r == ST_DONE) && oor_r |-> (res_r == 64'd0), "flag with data")
  `ASSERT_DEF(a_pos_live, (state_r == ST_DIG) || (state_r == ST_ADD) |-> (pos_r != 4'd0), "pos 0")
  `ASSERT_DEF(a_digit_dec, (state_r == ST_DIG) && (bit_r == 2'd0) |-> (dig_try <= 4'd9), "digit")
  `ASSERT_DEF(a_start, in_valid && in_ready |=> (state_r == ST_NEG) || (state_r == ST_MUL), "start")

endmodule

`default_nettype wire

// ----- rtl/packed_decimal_converter.sv -----
// Top level of the packed decimal converter: config registers, sequencer, output register.
// Converts one word at a time between 51-bit signed binary and sign-trailing packed
// decimal of up to 15 digits. Encode (kind 0) negates a negative value, checks its
// magnitude against the capacity of D = 2*packed_bytes-1 digits, flagging it out of range
// when it does not fit, then finds each digit by four restoring compare-subtract steps
// against shifted powers of ten on a single shared 52-bit adder. Decode (kind 1) makes two
// adder passes per digit for value*10+digit over 15 digits, then one for the negation.
// The input is not ready while a word is in work; a finished result sits in the output
// register so the next word can start while it waits.
`default_nettype none

module packed_decimal_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [50:0] in_value,
  input  logic [3:0]         in_packed_bytes,
  input  logic [63:0]        in_packed_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_packed_out,
  output logic signed [51:0] out_value_out,
  output logic               out_out_of_range,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  pdc_pkg::sign_cfg_t sign;
  pdc_pkg::res_t      res;
  logic               res_valid;
  logic               res_take;

  logic               out_valid_r, out_valid_nxt;
  pdc_pkg::res_t      out_r, out_nxt;

  pdc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .sign        (sign)
  );

  pdc_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_packed_bytes (in_packed_bytes),
    .in_packed_in    (in_packed_in),
    .sign            (sign),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res)
  );

  // Load the output register whenever it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_packed_out   = out_r.packed_out;
  assign out_value_out    = $signed(out_r.value_out);
  assign out_out_of_range = out_r.out_of_range;

endmodule

`default_nettype wire

// ----- sim/tb_packed_decimal_converter.sv -----
// Self-checking testbench for the packed decimal converter: encode, decode and sign registers.
`timescale 1ns / 100ps

localparam longint unsigned ENC_LIMIT = 64'd999_999_999_999_999;

function automatic longint unsigned pow_ten(input int n);
  longint unsigned p;
  p = 1;
  for (int i = 0; i < n; i++) p = p * 10;
  return p;
endfunction

class conversion_scoreboard;
  pdc_pkg::res_t pending_conversions[$];
  logic [3:0]    plus_code;
  logic [3:0]    minus_code;
  int            mismatches;

  function new();
    plus_code  = 4'd12;
    minus_code = 4'd13;
    mismatches = 0;
  endfunction

  function void set_sign_code(input logic idx, input logic [3:0] code);
    if (idx == pdc_pkg::REG_PLUS) begin
      plus_code = code;
    end else begin
      minus_code = code;
    end
  endfunction

  // Expected result of one word, from the current sign codes.
  function pdc_pkg::res_t convert_word(input logic kind, input logic [50:0] value,
                                       input logic [3:0] nbytes, input logic [63:0] packed_in);
    pdc_pkg::res_t   r;
    logic [50:0]     mag;
    longint unsigned m;
    int              digits;
    logic [51:0]     acc;
    r = '0;
    if (kind == pdc_pkg::KIND_ENC) begin
      mag    = value[50] ? (~value + 51'd1) : value;
      m      = {13'd0, mag};
      digits = 2 * int'(nbytes) - 1;
      if (nbytes == 4'd0 || nbytes > 4'd8 || m > ENC_LIMIT || m >= pow_ten(digits)) begin
        r.out_of_range = 1'b1;
      end else begin
        for (int pos = digits; pos > 0; pos--)
          r.packed_out[4*pos +: 4] = 4'((m / pow_ten(pos - 1)) % 10);
        r.packed_out[3:0] = value[50] ? minus_code : plus_code;
      end
    end else begin
      acc = '0;
      for (int k = 15; k >= 1; k--) acc = acc * 52'd10 + {48'd0, packed_in[4*k +: 4]};
      if (packed_in[3:0] == minus_code) acc = -acc;
      r.value_out = acc;
    end
    return r;
  endfunction

  function void note_word(input logic kind, input logic [50:0] value,
                          input logic [3:0] nbytes, input logic [63:0] packed_in);
    pending_conversions.push_back(convert_word(kind, value, nbytes, packed_in));
  endfunction

  function void check_result(input logic [63:0] p, input logic [51:0] v, input logic oor);
    pdc_pkg::res_t want;
    if (pending_conversions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: packed %h value %h range %b", p, v, oor);
    end else begin
      want = pending_conversions.pop_front();
      if (want.packed_out !== p || want.value_out !== v || want.out_of_range !== oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: packed %h/%h value %h/%h range %b/%b (expected/actual)",
                   want.packed_out, p, want.value_out, v, want.out_of_range, oor);
      end
    end
  endfunction

  function int pending();
    return pending_conversions.size();
  endfunction
endclass

module tb_packed_decimal_converter;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int WORDS_PER_SETTING = 235;

  typedef struct {
    logic        kind;
    logic [50:0] value;
    logic [3:0]  nbytes;
    logic [63:0] packed_in;
  } conv_word_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic signed [50:0] in_value;
  logic [3:0]         in_packed_bytes;
  logic [63:0]        in_packed_in;
  logic               out_valid;
  logic               out_ready;
  logic [63:0]        out_packed_out;
  logic signed [51:0] out_value_out;
  logic               out_out_of_range;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  conversion_scoreboard conv_sb;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  packed_decimal_converter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .in_packed_bytes  (in_packed_bytes),
    .in_packed_in     (in_packed_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packed_out   (out_packed_out),
    .out_value_out    (out_value_out),
    .out_out_of_range (out_out_of_range),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      conv_sb.check_result(out_packed_out, out_value_out, out_out_of_range);
  end

  // Present one word and hold it until accepted; the caller stands at a rising edge.
  task automatic send_word(input conv_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_kind         <= w.kind;
    in_value        <= w.value;
    in_packed_bytes <= w.nbytes;
    in_packed_in    <= w.packed_in;
    do @(posedge clk); while (!in_ready);
    conv_sb.note_word(w.kind, w.value, w.nbytes, w.packed_in);
  endtask

  task automatic encode_word(input logic [50:0] v, input logic [3:0] nb);
    conv_word_t w;
    w.kind      = pdc_pkg::KIND_ENC;
    w.value     = v;
    w.nbytes    = nb;
    w.packed_in = {$urandom, $urandom};
    send_word(w);
  endtask

  task automatic decode_word(input logic [63:0] p);
    conv_word_t w;
    w.kind      = pdc_pkg::KIND_DEC;
    w.value     = 51'({$urandom, $urandom});
    w.nbytes    = 4'($urandom_range(15));
    w.packed_in = p;
    send_word(w);
  endtask

  task automatic wait_drained();
    while (conv_sb.pending() != 0) @(posedge clk);
  endtask

  // Write both sign registers back to back; psel stays high between the two.
  task automatic write_sign_codes(input logic [3:0] plus_c, input logic [3:0] minus_c);
    logic       idx;
    logic [3:0] code;
    for (int i = 0; i < 2; i++) begin
      idx  = (i == 0) ? pdc_pkg::REG_PLUS : pdc_pkg::REG_MINUS;
      code = (i == 0) ? plus_c : minus_c;
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {idx, 2'b00};
      cfg_pwdata  <= {28'd0, code};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      conv_sb.set_sign_code(idx, code);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic conv_word_t random_word();
    conv_word_t      w;
    longint unsigned r64;
    longint unsigned mag;
    int              ndig;
    r64         = {$urandom, $urandom};
    w.value     = r64[50:0];
    w.nbytes    = 4'($urandom_range(15));
    w.packed_in = {$urandom, $urandom};
    w.kind      = ($urandom_range(99) < 55) ? pdc_pkg::KIND_ENC : pdc_pkg::KIND_DEC;
    if (w.kind == pdc_pkg::KIND_ENC) begin
      // mostly magnitudes of 1 to 15 digits, some at 10^n-1 or 10^n, rest raw noise
      if ($urandom_range(99) >= 10) begin
        w.nbytes = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
        ndig     = $urandom_range(15, 1);
        mag      = {$urandom, $urandom};
        mag      = mag % pow_ten(ndig);
        case ($urandom_range(7))
          0:       mag = pow_ten(ndig) - 1;
          1:       mag = pow_ten(ndig);
          default: ;
        endcase
        w.value = mag[50:0];
        if ($urandom_range(1) == 1) w.value = -w.value;
      end
    end else if ($urandom_range(99) >= 15) begin
      ndig        = $urandom_range(15);
      w.packed_in = '0;
      for (int k = 1; k <= ndig; k++) w.packed_in[4*k +: 4] = 4'($urandom_range(9));
      case ($urandom_range(3)) inside
        0:       w.packed_in[3:0] = conv_sb.plus_code;
        1, 2:    w.packed_in[3:0] = conv_sb.minus_code;
        default: w.packed_in[3:0] = 4'($urandom_range(15));
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [3:0] plus_tab [6];
    logic [3:0] minus_tab [6];
    plus_tab  = '{4'd12, 4'd0, 4'd15, 4'd9, 4'd10, 4'd12};
    minus_tab = '{4'd13, 4'd15, 4'd0, 4'd9, 4'd11, 4'd13};
    conv_sb         = new();
    cycle_count     = 0;
    send_idle_pct   = 16;
    recv_idle_pct   = 47;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= pdc_pkg::KIND_ENC;
    in_value        <= '0;
    in_packed_bytes <= '0;
    in_packed_in    <= '0;
    out_ready       <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset sign codes
    encode_word(51'd0, 4'd1);
    encode_word(51'd9, 4'd1);
    encode_word(-51'sd9, 4'd1);
    encode_word(51'd10, 4'd1);
    encode_word(51'd999, 4'd2);
    encode_word(51'd1000, 4'd2);
    encode_word(51'd1234567, 4'd4);
    encode_word(51'd999_999_999_999_999, 4'd8);
    encode_word(-51'sd999_999_999_999_999, 4'd8);
    encode_word(51'd1_000_000_000_000_000, 4'd8);
    encode_word(-51'sd1_000_000_000_000_000, 4'd8);
    encode_word({1'b1, 50'd0}, 4'd8);
    encode_word({1'b0, {50{1'b1}}}, 4'd8);
    encode_word(51'd123, 4'd0);
    encode_word(51'd123, 4'd9);
    encode_word(51'd123, 4'd15);
    decode_word(64'h9999_9999_9999_999D);
    decode_word(64'h9999_9999_9999_999C);
    decode_word(64'hFFFF_FFFF_FFFF_FFFF);
    decode_word(64'hFFFF_FFFF_FFFF_FFFD);
    decode_word(64'h0000_0000_0000_0000);
    decode_word(64'h0000_0000_0000_000D);
    decode_word(64'h1234_5678_9ABC_DEF0);
    decode_word(64'h0123_4567_8901_234B);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        // drop valid, drain, then change the sign codes while idle
        in_valid <= 1'b0;
        wait_drained();
        write_sign_codes(plus_tab[phase], minus_tab[phase]);
      end
      if (phase < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 47;
      end else if (phase < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (WORDS_PER_SETTING) send_word(random_word());
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (80) @(posedge clk);

    if (conv_sb.mismatches == 0 && conv_sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_addsub.sv
rtl/pdc_regs.sv
rtl/pdc_seq.sv
rtl/packed_decimal_converter.sv
sim/tb_packed_decimal_converter.sv
